// ===== sv/best_threshold_accuracy_assert.svh =====
// ----------------------------------------------------------------------------
// best_threshold_accuracy_assert
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef BEST_THRESHOLD_ACCURACY_ASSERT_SVH
`define BEST_THRESHOLD_ACCURACY_ASSERT_SVH

// Property holds on every clock edge outside reset.
`define BTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication holds on every clock edge outside reset.
`define BTA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// Types and constants for the best-threshold accuracy block.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int MAX_ROWS = 4096;
  localparam int NUM_BINS = 200;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int DATA_W = 32;

  // floor(r / (NUM_BINS-1)) == (r * (2^32 + STEP_RECIP)) >> STEP_SHIFT,
  // exact for any 32-bit unsigned r
  localparam logic [30:0] STEP_RECIP = 31'd1230216764;
  localparam int          STEP_SHIFT = 40;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_MINMAX,
    ST_STEP,
    ST_BIN_RD,
    ST_BIN_DIV,
    ST_BIN_WR,
    ST_SUMPOS,
    ST_SCAN,
    ST_ACC,
    ST_DONE
  } state_t;

  // Requests from the sequencer to the shared divider.
  typedef struct packed {
    logic              start;
    logic [63:0]       dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [63:0]       quotient;
  } div_rsp_t;

endpackage

// ===== sv/bta_divider.sv =====
// ----------------------------------------------------------------------------
// bta_divider
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module bta_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  bta_pkg::div_req_t req,
  output bta_pkg::div_rsp_t rsp
);

  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[63]} - {2'b00, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`include "best_threshold_accuracy_assert.svh"
  `BTA_ASSERT_IMP(a_done_after_busy, rsp.done, !busy_r, "divider done while busy")
  `BTA_ASSERT_IMP(a_cnt_zero_idle, !busy_r, cnt_r == 7'd0 || $past(req.start) == 1'b0, "count")
  `BTA_ASSERT_IMP(a_start_busy, req.start, ##1 busy_r, "divider not busy after start")

endmodule

// ===== sv/best_threshold_accuracy.sv =====
// ----------------------------------------------------------------------------
// best_threshold_accuracy
// Histogram sweep for the best single-threshold accuracy of a score column.
// ----------------------------------------------------------------------------
// Channel   Ports                                            Handshake
// input     in_prediction, in_target, in_last                start & !busy
// result    out_best_accuracy .. out_overflowed              out_valid strobe
//
// Loading: one sample per cycle. After a last sample the block stays busy up
// to and including the result strobe; the shared divider (one quotient bit a
// cycle) runs once for each binned sample unless all predictions are equal,
// and once more for the accuracy.
// Reset clears control state; the sample memory is not cleared.
// The result strobe lasts one cycle; the receiver cannot stall it.
module best_threshold_accuracy (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_prediction,
  input  logic        in_target,
  input  logic        in_last,
  output logic        out_valid,
  output logic [16:0] out_best_accuracy,
  output logic [12:0] out_best_correct,
  output logic [12:0] out_row_count,
  output logic [31:0] out_prediction_minimum,
  output logic [31:0] out_threshold_step,
  output logic        out_overflowed
);

  localparam int RW = bta_pkg::ROW_W;
  localparam int CW = bta_pkg::CNT_W;
  localparam int BW = bta_pkg::BIN_W;

  bta_pkg::state_t st_r, st_nxt;

  logic [32:0] smem [bta_pkg::MAX_ROWS];
  logic [CW-1:0] bin_tot [bta_pkg::NUM_BINS];
  logic [CW-1:0] bin_pos [bta_pkg::NUM_BINS];
  logic [32:0] rd_r;
  logic [CW-1:0] tot_rd_r, pos_rd_r;

  logic [CW-1:0] rows_r, rows_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic signed [31:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [32:0]   range_r, range_nxt;
  logic [31:0]   step_r, step_nxt;
  logic [62:0]   mul_r, mul_nxt;
  logic [32:0]   cur_r, cur_nxt;
  logic [BW-1:0] bin_r, bin_nxt;
  logic [CW-1:0] allpos_r, allpos_nxt, ctot_r, ctot_nxt, cpos_r, cpos_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [16:0]   acc_r, acc_nxt;
  logic          div_wait_r, div_wait_nxt;

  logic          accept;
  logic          mem_we;
  logic [RW-1:0] mem_wa;
  logic          bin_we, bin_clr;
  logic [BW-1:0] bin_wa;
  logic [CW-1:0] bin_wt, bin_wp;
  logic [BW-1:0] bin_ra;
  logic [RW-1:0] mem_ra;

  bta_pkg::div_req_t div_req;
  bta_pkg::div_rsp_t div_rsp;

  logic [CW:0]   correct;
  logic [32:0]   dval;
  logic [63:0]   qclip;
  logic [64:0]   step_sum;

  bta_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign accept = start && !busy;
  assign busy   = (st_r != bta_pkg::ST_LOAD);

  always_ff @(posedge clk) begin
    if (mem_we) smem[mem_wa] <= {in_target, in_prediction};
    rd_r <= smem[mem_ra];
    if (bin_we) begin
      bin_tot[bin_wa] <= bin_wt;
      bin_pos[bin_wa] <= bin_wp;
    end
    tot_rd_r <= bin_tot[bin_ra];
    pos_rd_r <= bin_pos[bin_ra];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bta_pkg::ST_LOAD:   if (accept && in_last) st_nxt = bta_pkg::ST_CLEAR;
      bta_pkg::ST_CLEAR:
        if (idx_r == CW'(bta_pkg::NUM_BINS - 1)) begin
          st_nxt = (rows_r == '0) ? bta_pkg::ST_DONE : bta_pkg::ST_MINMAX;
        end
      bta_pkg::ST_MINMAX: if (idx_r == rows_r) st_nxt = bta_pkg::ST_STEP;
      bta_pkg::ST_STEP:   if (idx_r == CW'(2)) st_nxt = bta_pkg::ST_BIN_RD;
      bta_pkg::ST_BIN_RD: st_nxt = (idx_r == rows_r) ? bta_pkg::ST_SUMPOS : bta_pkg::ST_BIN_DIV;
      bta_pkg::ST_BIN_DIV:
        if (range_r == '0 || (div_wait_r && div_rsp.done)) st_nxt = bta_pkg::ST_BIN_WR;
      bta_pkg::ST_BIN_WR: st_nxt = bta_pkg::ST_BIN_RD;
      bta_pkg::ST_SUMPOS: if (idx_r == CW'(bta_pkg::NUM_BINS + 1)) st_nxt = bta_pkg::ST_SCAN;
      bta_pkg::ST_SCAN:   if (idx_r == CW'(bta_pkg::NUM_BINS + 1)) st_nxt = bta_pkg::ST_ACC;
      bta_pkg::ST_ACC:    if (div_wait_r && div_rsp.done) st_nxt = bta_pkg::ST_DONE;
      bta_pkg::ST_DONE:   st_nxt = bta_pkg::ST_LOAD;
      default:            st_nxt = bta_pkg::ST_LOAD;
    endcase
  end

  // signed difference x - min, never negative, fits 33 bits
  assign dval    = {rd_r[31], rd_r[31:0]} - {lo_r[31], lo_r};
  assign qclip   = div_rsp.quotient;
  assign correct = {1'b0, allpos_r} - {1'b0, cpos_r} + {1'b0, ctot_r} - {1'b0, cpos_r};
  assign mul_nxt = 63'(range_r[31:0]) * 63'(bta_pkg::STEP_RECIP);
  assign step_sum = {1'b0, range_r[31:0], 32'd0} + {2'b00, mul_r};

  always_comb begin
    rows_nxt = rows_r; ovf_nxt = ovf_r; idx_nxt = idx_r; rd_ok_nxt = 1'b0;
    lo_nxt = lo_r; hi_nxt = hi_r; range_nxt = range_r; step_nxt = step_r;
    cur_nxt = cur_r; bin_nxt = bin_r; allpos_nxt = allpos_r; ctot_nxt = ctot_r;
    cpos_nxt = cpos_r; best_nxt = best_r; acc_nxt = acc_r; div_wait_nxt = div_wait_r;
    mem_we = 1'b0; mem_wa = rows_r[RW-1:0]; mem_ra = idx_r[RW-1:0];
    bin_we = 1'b0; bin_clr = 1'b0; bin_wa = idx_r[BW-1:0];
    bin_wt = '0; bin_wp = '0; bin_ra = idx_r[BW-1:0];
    div_req = '0;
    unique case (st_r)
      bta_pkg::ST_LOAD: begin
        idx_nxt = '0;
        if (accept) begin
          if (rows_r < CW'(bta_pkg::MAX_ROWS)) begin
            mem_we = 1'b1;
            rows_nxt = rows_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      bta_pkg::ST_CLEAR: begin
        bin_we = 1'b1; bin_clr = 1'b1;
        idx_nxt = (idx_r == CW'(bta_pkg::NUM_BINS - 1)) ? '0 : idx_r + CW'(1);
      end
      bta_pkg::ST_MINMAX: begin
        // memory read data is registered; rd_ok marks valid data
        if (idx_r != rows_r) idx_nxt = idx_r + CW'(1);
        rd_ok_nxt = (idx_r != rows_r);
        if (rd_ok_r) begin
          if (idx_r == CW'(1)) begin
            lo_nxt = $signed(rd_r[31:0]); hi_nxt = $signed(rd_r[31:0]);
          end else begin
            if ($signed(rd_r[31:0]) < lo_r) lo_nxt = $signed(rd_r[31:0]);
            if ($signed(rd_r[31:0]) > hi_r) hi_nxt = $signed(rd_r[31:0]);
          end
        end
        if (idx_r == rows_r) idx_nxt = '0;
      end
      bta_pkg::ST_STEP: begin
        // range, then registered reciprocal product, then add and shift
        range_nxt = {hi_r[31], hi_r} - {lo_r[31], lo_r};
        idx_nxt = idx_r + CW'(1);
        if (idx_r == CW'(2)) begin
          step_nxt = 32'(step_sum >> bta_pkg::STEP_SHIFT);
          idx_nxt = '0;
        end
      end
      bta_pkg::ST_BIN_RD: begin
        // address set now; data arrives next state
        mem_ra = idx_r[RW-1:0];
        if (idx_r == rows_r) idx_nxt = '0;
      end
      bta_pkg::ST_BIN_DIV: begin
        mem_ra = idx_r[RW-1:0];
        cur_nxt = rd_r;
        if (range_r == '0) begin
          bin_nxt = '0;
        end else if (!div_wait_r) begin
          div_req.start = 1'b1;
          div_req.dividend = 64'(dval) * 64'(bta_pkg::NUM_BINS - 1);
          div_req.divisor = range_r[31:0];
          div_wait_nxt = 1'b1;
        end else if (div_rsp.done) begin
          div_wait_nxt = 1'b0;
          bin_nxt = (qclip > 64'(bta_pkg::NUM_BINS - 1)) ? BW'(bta_pkg::NUM_BINS - 1)
                                                          : qclip[BW-1:0];
        end
        bin_ra = bin_nxt;
      end
      bta_pkg::ST_BIN_WR: begin
        bin_we = 1'b1; bin_wa = bin_r;
        bin_wt = tot_rd_r + CW'(1);
        bin_wp = pos_rd_r + CW'(cur_r[32]);
        idx_nxt = idx_r + CW'(1);
        if (idx_nxt == rows_r) idx_nxt = rows_r;
        if (idx_r + CW'(1) == rows_r) idx_nxt = rows_r;
      end
      bta_pkg::ST_SUMPOS: begin
        if (idx_r == '0) allpos_nxt = '0;
        else allpos_nxt = allpos_r + pos_rd_r;
        bin_ra = idx_r[BW-1:0];
        idx_nxt = (idx_r == CW'(bta_pkg::NUM_BINS + 1)) ? '0 : idx_r + CW'(1);
        if (idx_r == CW'(bta_pkg::NUM_BINS + 1)) allpos_nxt = allpos_r;
        if (idx_r == CW'(bta_pkg::NUM_BINS + 1)) begin
          ctot_nxt = '0; cpos_nxt = '0; best_nxt = '0;
        end
      end
      bta_pkg::ST_SCAN: begin
        bin_ra = idx_r[BW-1:0];
        if (idx_r >= CW'(1) && idx_r <= CW'(bta_pkg::NUM_BINS)) begin
          ctot_nxt = ctot_r + tot_rd_r;
          cpos_nxt = cpos_r + pos_rd_r;
        end
        if (idx_r >= CW'(2) && correct > {1'b0, best_r}) best_nxt = correct[CW-1:0];
        idx_nxt = (idx_r == CW'(bta_pkg::NUM_BINS + 1)) ? '0 : idx_r + CW'(1);
      end
      bta_pkg::ST_ACC: begin
        if (!div_wait_r) begin
          div_req.start = 1'b1;
          div_req.dividend = {35'd0, best_r, 16'd0};
          div_req.divisor = 32'(rows_r);
          div_wait_nxt = 1'b1;
        end else if (div_rsp.done) begin
          div_wait_nxt = 1'b0;
          acc_nxt = qclip[16:0];
        end
      end
      bta_pkg::ST_DONE: begin
        rows_nxt = '0; ovf_nxt = 1'b0;
      end
      default: ;
    endcase
    if (bin_clr) begin bin_wt = '0; bin_wp = '0; end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; range_r <= range_nxt; step_r <= step_nxt;
    mul_r <= mul_nxt;
    cur_r <= cur_nxt; bin_r <= bin_nxt; allpos_r <= allpos_nxt; ctot_r <= ctot_nxt;
    cpos_r <= cpos_nxt; best_r <= best_nxt; acc_r <= acc_nxt;
    if (!rst_n) begin
      st_r <= bta_pkg::ST_LOAD; rows_r <= '0; ovf_r <= 1'b0; idx_r <= '0;
      rd_ok_r <= 1'b0; div_wait_r <= 1'b0;
    end else begin
      st_r <= st_nxt; rows_r <= rows_nxt; ovf_r <= ovf_nxt; idx_r <= idx_nxt;
      rd_ok_r <= rd_ok_nxt; div_wait_r <= div_wait_nxt;
    end
  end

  logic empty;
  assign empty                  = (rows_r == '0);
  assign out_valid              = (st_r == bta_pkg::ST_DONE);
  assign out_best_accuracy      = empty ? '0 : acc_r;
  assign out_best_correct       = empty ? '0 : best_r;
  assign out_row_count          = rows_r;
  assign out_prediction_minimum = empty ? '0 : lo_r;
  assign out_threshold_step     = empty ? '0 : step_r;
  assign out_overflowed         = ovf_r;

`include "best_threshold_accuracy_assert.svh"
  `BTA_ASSERT_IMP(a_no_accept_busy, busy, !accept, "accept while busy")
  `BTA_ASSERT_IMP(a_rows_cap, 1'b1, rows_r <= CW'(bta_pkg::MAX_ROWS), "row count too big")
  `BTA_ASSERT_IMP(a_strobe_one, out_valid, ##1 !out_valid, "result strobe too long")

endmodule
